### src/shape_pair_collision_test_unit_defines.svh
// Assertion macros shared by the shape pair collision test unit modules.
`ifndef SHAPE_PAIR_COLLISION_TEST_UNIT_DEFINES_SVH
`define SHAPE_PAIR_COLLISION_TEST_UNIT_DEFINES_SVH

// Expression must never be true outside reset.
`define SPCT_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion violated");

// Consequent must hold in the cycle after the antecedent.
`define SPCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

### src/spct_pkg.sv
// Package: widths, codes and the job record of the shape pair collision test unit.
`timescale 1ns / 1ps
`default_nettype none
package spct_pkg;

   localparam int FRAC_BITS   = 10;
   localparam int KIND_W      = 2;
   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 31;
   localparam int HALF_W      = SIZE_W - 1;
   localparam int EXT_W       = SIZE_W;
   localparam int DIST_W      = COORD_W;
   localparam int IPART_W     = COORD_W + 1 - FRAC_BITS;
   localparam int SQ_W        = 2 * DIST_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1) + 1;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_PIXEL_APPROX = 1'b0;

   localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd2;

   // pair classes after ordering the two shapes
   localparam int CLS_W = 3;
   localparam logic [CLS_W-1:0] CLS_NONE = 3'd0;
   localparam logic [CLS_W-1:0] CLS_PP   = 3'd1;
   localparam logic [CLS_W-1:0] CLS_RP   = 3'd2;
   localparam logic [CLS_W-1:0] CLS_RR   = 3'd3;
   localparam logic [CLS_W-1:0] CLS_CP   = 3'd4;
   localparam logic [CLS_W-1:0] CLS_CR   = 3'd5;
   localparam logic [CLS_W-1:0] CLS_CC   = 3'd6;

   typedef struct packed {
      logic [CLS_W-1:0]   cls;
      logic [DIST_W-1:0]  ux;
      logic [DIST_W-1:0]  uy;
      logic [DIST_W-1:0]  lx;
      logic [DIST_W-1:0]  ly;
      logic [HALF_W-1:0]  hx;
      logic [HALF_W-1:0]  hy;
      logic [DIST_W-1:0]  rr;
      logic [IPART_W-1:0] lo_x;
      logic [IPART_W-1:0] hi_x;
      logic [IPART_W-1:0] pt_x;
      logic [IPART_W-1:0] lo_y;
      logic [IPART_W-1:0] hi_y;
      logic [IPART_W-1:0] pt_y;
   } job_type;

endpackage
`default_nettype wire

### src/spct_front.sv
// Front end: accepts requests, orders the shape pair and forms distances and limits.
`timescale 1ns / 1ps
`default_nettype none
`include "shape_pair_collision_test_unit_defines.svh"
module spct_front import spct_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_a_kind,
   input  logic [COORD_W-1:0]  req_a_x,
   input  logic [COORD_W-1:0]  req_a_y,
   input  logic [SIZE_W-1:0]   req_a_width,
   input  logic [SIZE_W-1:0]   req_a_height,
   input  logic [SIZE_W-1:0]   req_a_radius,
   input  logic [KIND_W-1:0]   req_b_kind,
   input  logic [COORD_W-1:0]  req_b_x,
   input  logic [COORD_W-1:0]  req_b_y,
   input  logic [SIZE_W-1:0]   req_b_width,
   input  logic [SIZE_W-1:0]   req_b_height,
   input  logic [SIZE_W-1:0]   req_b_radius,
   input  logic [QCNT_W-1:0]   q_count,
   output logic                push,
   output job_type             push_job
);

   logic                accept;
   logic [QCNT_W-1:0]   occ;
   logic [HALF_W-1:0]   ahw, ahh, bhw, bhh;

   logic                f1_valid_ff;
   logic [CLS_W-1:0]    f1_cls_in, f1_cls_ff;
   logic [COORD_W-1:0]  f1_sx_in, f1_sx_ff, f1_sy_in, f1_sy_ff;
   logic [COORD_W-1:0]  f1_ox_in, f1_ox_ff, f1_oy_in, f1_oy_ff;
   logic [EXT_W-1:0]    f1_e1x_in, f1_e1x_ff, f1_e2x_in, f1_e2x_ff;
   logic [EXT_W-1:0]    f1_e1y_in, f1_e1y_ff, f1_e2y_in, f1_e2y_ff;
   logic [HALF_W-1:0]   f1_hx_in, f1_hx_ff, f1_hy_in, f1_hy_ff;
   logic [EXT_W-1:0]    f1_r1_in, f1_r1_ff, f1_r2_in, f1_r2_ff;

   logic                f2_valid_ff;
   job_type             f2_job_in, f2_job_ff;

   logic [COORD_W:0]    sx_w, sy_w, ox_w, oy_w;
   logic [COORD_W:0]    dx_so, dx_os, dy_so, dy_os;
   logic [COORD_W:0]    lo_x_w, hi_x_w, lo_y_w, hi_y_w;

   // items in flight never exceed the queue depth
   assign occ       = q_count + QCNT_W'(f1_valid_ff) + QCNT_W'(f2_valid_ff);
   assign req_stall = (occ >= QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign ahw = req_a_width[SIZE_W-1:1];
   assign ahh = req_a_height[SIZE_W-1:1];
   assign bhw = req_b_width[SIZE_W-1:1];
   assign bhh = req_b_height[SIZE_W-1:1];

   always_comb begin
      f1_cls_in = CLS_NONE;
      f1_sx_in  = req_a_x;
      f1_sy_in  = req_a_y;
      f1_ox_in  = req_b_x;
      f1_oy_in  = req_b_y;
      f1_e1x_in = '0;
      f1_e2x_in = '0;
      f1_e1y_in = '0;
      f1_e2y_in = '0;
      f1_hx_in  = '0;
      f1_hy_in  = '0;
      f1_r1_in  = '0;
      f1_r2_in  = '0;
      case ({req_a_kind, req_b_kind})
         {KIND_POINT, KIND_POINT}: begin
            f1_cls_in = CLS_PP;
         end
         {KIND_POINT, KIND_RECT}: begin
            f1_cls_in = CLS_RP;
            f1_sx_in  = req_b_x;
            f1_sy_in  = req_b_y;
            f1_ox_in  = req_a_x;
            f1_oy_in  = req_a_y;
            f1_e1x_in = {1'b0, bhw};
            f1_e1y_in = {1'b0, bhh};
         end
         {KIND_POINT, KIND_CIRCLE}: begin
            f1_cls_in = CLS_CP;
            f1_e1x_in = req_b_radius;
            f1_e1y_in = req_b_radius;
            f1_r1_in  = req_b_radius;
         end
         {KIND_RECT, KIND_POINT}: begin
            f1_cls_in = CLS_RP;
            f1_e1x_in = {1'b0, ahw};
            f1_e1y_in = {1'b0, ahh};
         end
         {KIND_RECT, KIND_RECT}: begin
            f1_cls_in = CLS_RR;
            f1_e1x_in = {1'b0, ahw};
            f1_e2x_in = {1'b0, bhw};
            f1_e1y_in = {1'b0, ahh};
            f1_e2y_in = {1'b0, bhh};
         end
         {KIND_RECT, KIND_CIRCLE}: begin
            f1_cls_in = CLS_CR;
            f1_e1x_in = {1'b0, ahw};
            f1_e2x_in = req_b_radius;
            f1_e1y_in = {1'b0, ahh};
            f1_e2y_in = req_b_radius;
            f1_hx_in  = ahw;
            f1_hy_in  = ahh;
            f1_r1_in  = req_b_radius;
         end
         {KIND_CIRCLE, KIND_POINT}: begin
            f1_cls_in = CLS_CP;
            f1_e1x_in = req_a_radius;
            f1_e1y_in = req_a_radius;
            f1_r1_in  = req_a_radius;
         end
         {KIND_CIRCLE, KIND_RECT}: begin
            f1_cls_in = CLS_CR;
            f1_e1x_in = {1'b0, bhw};
            f1_e2x_in = req_a_radius;
            f1_e1y_in = {1'b0, bhh};
            f1_e2y_in = req_a_radius;
            f1_hx_in  = bhw;
            f1_hy_in  = bhh;
            f1_r1_in  = req_a_radius;
         end
         {KIND_CIRCLE, KIND_CIRCLE}: begin
            f1_cls_in = CLS_CC;
            f1_e1x_in = req_a_radius;
            f1_e2x_in = req_b_radius;
            f1_e1y_in = req_a_radius;
            f1_e2y_in = req_b_radius;
            f1_r1_in  = req_a_radius;
            f1_r2_in  = req_b_radius;
         end
         default: begin
            f1_cls_in = CLS_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_cls_ff <= f1_cls_in;
      f1_sx_ff  <= f1_sx_in;
      f1_sy_ff  <= f1_sy_in;
      f1_ox_ff  <= f1_ox_in;
      f1_oy_ff  <= f1_oy_in;
      f1_e1x_ff <= f1_e1x_in;
      f1_e2x_ff <= f1_e2x_in;
      f1_e1y_ff <= f1_e1y_in;
      f1_e2y_ff <= f1_e2y_in;
      f1_hx_ff  <= f1_hx_in;
      f1_hy_ff  <= f1_hy_in;
      f1_r1_ff  <= f1_r1_in;
      f1_r2_ff  <= f1_r2_in;
      f2_job_ff <= f2_job_in;
   end

   assign sx_w = {f1_sx_ff[COORD_W-1], f1_sx_ff};
   assign sy_w = {f1_sy_ff[COORD_W-1], f1_sy_ff};
   assign ox_w = {f1_ox_ff[COORD_W-1], f1_ox_ff};
   assign oy_w = {f1_oy_ff[COORD_W-1], f1_oy_ff};

   assign dx_so = sx_w - ox_w;
   assign dx_os = ox_w - sx_w;
   assign dy_so = sy_w - oy_w;
   assign dy_os = oy_w - sy_w;

   // rectangle bounds for the integer-part tests
   assign lo_x_w = sx_w - {2'b00, f1_e1x_ff};
   assign hi_x_w = sx_w + {2'b00, f1_e1x_ff};
   assign lo_y_w = sy_w - {2'b00, f1_e1y_ff};
   assign hi_y_w = sy_w + {2'b00, f1_e1y_ff};

   always_comb begin
      f2_job_in.cls  = f1_cls_ff;
      f2_job_in.ux   = dx_so[COORD_W] ? dx_os[DIST_W-1:0] : dx_so[DIST_W-1:0];
      f2_job_in.uy   = dy_so[COORD_W] ? dy_os[DIST_W-1:0] : dy_so[DIST_W-1:0];
      f2_job_in.lx   = {1'b0, f1_e1x_ff} + {1'b0, f1_e2x_ff};
      f2_job_in.ly   = {1'b0, f1_e1y_ff} + {1'b0, f1_e2y_ff};
      f2_job_in.hx   = f1_hx_ff;
      f2_job_in.hy   = f1_hy_ff;
      f2_job_in.rr   = {1'b0, f1_r1_ff} + {1'b0, f1_r2_ff};
      f2_job_in.lo_x = lo_x_w[COORD_W:FRAC_BITS];
      f2_job_in.hi_x = hi_x_w[COORD_W:FRAC_BITS];
      f2_job_in.pt_x = ox_w[COORD_W:FRAC_BITS];
      f2_job_in.lo_y = lo_y_w[COORD_W:FRAC_BITS];
      f2_job_in.hi_y = hi_y_w[COORD_W:FRAC_BITS];
      f2_job_in.pt_y = oy_w[COORD_W:FRAC_BITS];
   end

   assign push     = f2_valid_ff;
   assign push_job = f2_job_ff;

   `SPCT_ASSERT_NEVER(a_front_occupancy, clock, reset, occ > QCNT_W'(QUEUE_DEPTH))
   `SPCT_ASSERT_NEXT(a_front_flow, clock, reset, f1_valid_ff, f2_valid_ff)

endmodule
`default_nettype wire

### src/spct_queue.sv
// Job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "shape_pair_collision_test_unit_defines.svh"
module spct_queue import spct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head_job,
   output logic              q_empty,
   output logic [QCNT_W-1:0] q_count
);

   job_type             q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                q_full;

   assign q_empty  = (count_ff == '0);
   assign q_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_count  = count_ff;
   assign head_job = q_mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_job;
      end
   end

   `SPCT_ASSERT_NEVER(a_queue_overflow, clock, reset, push && q_full && !pop)
   `SPCT_ASSERT_NEVER(a_queue_underflow, clock, reset, pop && q_empty)

endmodule
`default_nettype wire

### src/spct_back.sv
// Back end: range compares, squared distance test and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "shape_pair_collision_test_unit_defines.svh"
module spct_back import spct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pixel_approx,
   input  logic     q_empty,
   input  job_type  head_job,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     rsp_hit
);

   logic                b_en;
   logic                reject, in_span, pix_ok;
   logic                fin_in, need_in;
   logic [DIST_W-1:0]   ex_in, ey_in;

   logic                b1_valid_ff, b1_fin_ff, b1_need_ff;
   logic [DIST_W-1:0]   b1_ex_ff, b1_ey_ff, b1_rr_ff;

   logic                b2_valid_ff, b2_fin_ff, b2_need_ff;
   logic [SQ_W-1:0]     b2_exx_ff, b2_eyy_ff, b2_rrr_ff;

   logic [SQ_W:0]       sq_sum;
   logic                sq_ok;
   logic                rsp_valid_ff, rsp_hit_ff, rsp_hit_in;

   // whole back end holds while a result waits
   assign b_en = !(rsp_valid_ff && rsp_stall);
   assign pop  = b_en && !q_empty;

   assign reject  = (head_job.ux > head_job.lx) || (head_job.uy > head_job.ly);
   assign in_span = (head_job.ux <= {2'b00, head_job.hx}) ||
                    (head_job.uy <= {2'b00, head_job.hy});
   assign ex_in  = head_job.ux - {2'b00, head_job.hx};
   assign ey_in  = head_job.uy - {2'b00, head_job.hy};
   assign pix_ok = ($signed(head_job.lo_x) <= $signed(head_job.pt_x)) &&
                   ($signed(head_job.pt_x) <= $signed(head_job.hi_x)) &&
                   ($signed(head_job.lo_y) <= $signed(head_job.pt_y)) &&
                   ($signed(head_job.pt_y) <= $signed(head_job.hi_y));

   always_comb begin
      fin_in  = 1'b0;
      need_in = 1'b0;
      case (head_job.cls)
         CLS_PP, CLS_RP: begin
            fin_in = pixel_approx ? pix_ok : !reject;
         end
         CLS_RR: begin
            fin_in = !reject;
         end
         CLS_CP, CLS_CC: begin
            need_in = !reject;
         end
         CLS_CR: begin
            fin_in  = !reject && in_span;
            need_in = !reject && !in_span;
         end
         default: begin
            fin_in  = 1'b0;
            need_in = 1'b0;
         end
      endcase
   end

   assign sq_sum     = {1'b0, b2_exx_ff} + {1'b0, b2_eyy_ff};
   assign sq_ok      = (sq_sum <= {1'b0, b2_rrr_ff});
   assign rsp_hit_in = b2_need_ff ? sq_ok : b2_fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (b_en) begin
         b1_valid_ff  <= !q_empty;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b1_fin_ff  <= fin_in;
         b1_need_ff <= need_in;
         b1_ex_ff   <= ex_in;
         b1_ey_ff   <= ey_in;
         b1_rr_ff   <= head_job.rr;
         b2_fin_ff  <= b1_fin_ff;
         b2_need_ff <= b1_need_ff;
         b2_exx_ff  <= SQ_W'(b1_ex_ff) * SQ_W'(b1_ex_ff);
         b2_eyy_ff  <= SQ_W'(b1_ey_ff) * SQ_W'(b1_ey_ff);
         b2_rrr_ff  <= SQ_W'(b1_rr_ff) * SQ_W'(b1_rr_ff);
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   `SPCT_ASSERT_NEXT(a_back_hold, clock, reset, !b_en, $stable(b2_valid_ff))
   `SPCT_ASSERT_NEVER(a_back_decided, clock, reset, b1_valid_ff && b1_need_ff && b1_fin_ff)

endmodule
`default_nettype wire

### src/shape_pair_collision_test_unit.sv
// Top level: shape pair collision test unit with its control register port.
//
// Request channel (req_*): one shape pair per request, each shape a point,
// rectangle or circle with centre in signed 22.10 fixed point. A request
// is taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): exactly one rsp_hit per request, in order,
// taken at an edge with rsp_valid high and rsp_stall low.
// Control port (csr_*): one register at addresses 0-3, bit 0 pixel_approx;
// write only while the unit is idle. csr_pready is always high.
// While responses are not stalled, one request per cycle is sustained
// through the two-stage front end, the four-entry job queue and the
// three-stage back end with its multipliers.
// A stalled response holds the back end; the front end keeps accepting
// until the queue and front stages hold four jobs, then raises req_stall.
// Synchronous reset empties all stages and the queue and clears
// pixel_approx to 0.
`timescale 1ns / 1ps
`default_nettype none
module shape_pair_collision_test_unit import spct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_a_kind,
   input  logic [COORD_W-1:0]     req_a_x,
   input  logic [COORD_W-1:0]     req_a_y,
   input  logic [SIZE_W-1:0]      req_a_width,
   input  logic [SIZE_W-1:0]      req_a_height,
   input  logic [SIZE_W-1:0]      req_a_radius,
   input  logic [KIND_W-1:0]      req_b_kind,
   input  logic [COORD_W-1:0]     req_b_x,
   input  logic [COORD_W-1:0]     req_b_y,
   input  logic [SIZE_W-1:0]      req_b_width,
   input  logic [SIZE_W-1:0]      req_b_height,
   input  logic [SIZE_W-1:0]      req_b_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic               pixel_approx_ff;
   logic               csr_hit;
   logic               push, pop, q_empty;
   logic [QCNT_W-1:0]  q_count;
   job_type            push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_PIXEL_APPROX);
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, pixel_approx_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_approx_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         pixel_approx_ff <= csr_pwdata[0];
      end
   end

   spct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_a_kind   (req_a_kind),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_width  (req_a_width),
      .req_a_height (req_a_height),
      .req_a_radius (req_a_radius),
      .req_b_kind   (req_b_kind),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_width  (req_b_width),
      .req_b_height (req_b_height),
      .req_b_radius (req_b_radius),
      .q_count      (q_count),
      .push         (push),
      .push_job     (push_job)
   );

   spct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_empty  (q_empty),
      .q_count  (q_count)
   );

   spct_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pixel_approx (pixel_approx_ff),
      .q_empty      (q_empty),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit)
   );

endmodule
`default_nettype wire
